[design/cdir_pkg.sv]
package cdir_pkg;

  // Defaults for the top-level parameters
  localparam int CDIR_CACHE_COUNT = 8;
  localparam int CDIR_LINE_COUNT  = 1024;

  // Fixed field widths
  localparam int ADDR_W   = 32;
  localparam int ID_W     = 3;
  localparam int LSTATE_W = 2;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_INV_ACK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MT_READ_ACK   = 2'd0,
    MT_INVALIDATE = 2'd1,
    MT_WRITE_ACK  = 2'd2
  } msg_type_t;

  typedef enum logic [1:0] {
    SK_MEMORY    = 2'd0,
    SK_DIRECTORY = 2'd1,
    SK_CACHE     = 2'd2
  } sender_kind_t;

  typedef enum logic [1:0] {
    LS_UNCACHED  = 2'd0,
    LS_SHARED    = 2'd1,
    LS_EXCLUSIVE = 2'd2
  } line_state_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_EVAL,
    ST_SEND
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic mem_read;
    logic eval;
    logic send;
  } cdir_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic idx_done;
    logic has_final;
    logic out_free;
    logic mask_empty;
  } cdir_status_t;

endpackage

[design/cdir_if.sv]
interface cdir_req_if import cdir_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [ADDR_W-1:0] address;
  logic [ID_W-1:0]   source_id;

  modport source (output valid, output operation, output address, output source_id,
                  input ready);
  modport sink   (input valid, input operation, input address, input source_id,
                  output ready);
endinterface

interface cdir_msg_if import cdir_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        msg_type;
  logic [ID_W-1:0]   dest_id;
  logic [1:0]        sender_kind;
  logic [ID_W-1:0]   sender_cache;
  logic [ADDR_W-1:0] msg_address;
  logic              last;

  modport source (output valid, output msg_type, output dest_id, output sender_kind,
                  output sender_cache, output msg_address, output last, input ready);
  modport sink   (input valid, input msg_type, input dest_id, input sender_kind,
                  input sender_cache, input msg_address, input last, output ready);
endinterface

[design/cdir_line_index.sv]
module cdir_line_index import cdir_pkg::*; #(
  parameter int LINE_COUNT = CDIR_LINE_COUNT,
  localparam int IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] address,
  output logic              done,
  output logic [IDX_W-1:0]  index
);

  if ((LINE_COUNT & (LINE_COUNT - 1)) == 0) begin : g_pow2
    logic [IDX_W-1:0] low_r;

    // Take the low address bits as the line
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        low_r <= '0;
      end else if (start) begin
        low_r <= address[IDX_W-1:0];
      end
    end

    assign index = (LINE_COUNT == 1) ? '0 : low_r;
    assign done  = 1'b1;
  end else begin : g_recip
    // Scaled reciprocal of the line count; the quotient is the high word of
    // one product plus a fix-up
    localparam longint unsigned RECIP_WIDE =
      ((64'd1 << ADDR_W) * ((64'd1 << IDX_W) - 64'(LINE_COUNT))) / 64'(LINE_COUNT) + 64'd1;
    localparam logic [ADDR_W-1:0] RECIP  = ADDR_W'(RECIP_WIDE);
    localparam logic [IDX_W-1:0]  LC_LOW = IDX_W'(LINE_COUNT);

    logic [ADDR_W-1:0]   addr_r;
    logic [ADDR_W-1:0]   hi_r;
    logic [ADDR_W-1:0]   hi_nxt;
    logic [ADDR_W-1:0]   quot_r;
    logic [ADDR_W-1:0]   quot_nxt;
    logic [IDX_W-1:0]    rem_r;
    logic [IDX_W-1:0]    rem_nxt;
    logic [2:0]          stage_r;
    logic [2*ADDR_W-1:0] prod;
    logic [2*IDX_W-1:0]  quot_lc;

    // High word of address times reciprocal
    assign prod   = (2*ADDR_W)'(addr_r) * (2*ADDR_W)'(RECIP);
    assign hi_nxt = prod[2*ADDR_W-1:ADDR_W];

    // Fix up and shift down to the quotient
    assign quot_nxt = (hi_r + ((addr_r - hi_r) >> 1)) >> (IDX_W - 1);

    // Remainder is below the line count, so the low bits carry all of it
    assign quot_lc = (2*IDX_W)'(quot_r[IDX_W-1:0]) * (2*IDX_W)'(LC_LOW);
    assign rem_nxt = addr_r[IDX_W-1:0] - quot_lc[IDX_W-1:0];

    always_ff @(posedge clk) begin
      if (start) begin
        addr_r <= address;
      end
      if (stage_r[0]) begin
        hi_r <= hi_nxt;
      end
      if (stage_r[1]) begin
        quot_r <= quot_nxt;
      end
      if (stage_r[2]) begin
        rem_r <= rem_nxt;
      end
    end

    // Advance one stage per cycle after start
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r <= '0;
      end else begin
        stage_r <= {stage_r[1:0], start};
      end
    end

    assign index = rem_r;
    assign done  = (stage_r == '0);
  end

endmodule

[design/cdir_dpath.sv]
module cdir_dpath import cdir_pkg::*; #(
  parameter int CACHE_COUNT = CDIR_CACHE_COUNT,
  parameter int LINE_COUNT  = CDIR_LINE_COUNT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cdir_cmd_t         cmd,
  output cdir_status_t      status,
  input  logic [1:0]        in_operation,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [ID_W-1:0]   in_source_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_msg_type,
  output logic [ID_W-1:0]   out_dest_id,
  output logic [1:0]        out_sender_kind,
  output logic [ID_W-1:0]   out_sender_cache,
  output logic [ADDR_W-1:0] out_msg_address,
  output logic              out_last
);

  localparam int IDX_W   = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  // source_id names caches 0 to 7 only, so no more sharer bits are kept
  localparam int SH_W    = (CACHE_COUNT < 8) ? CACHE_COUNT : 8;
  localparam int ENTRY_W = LSTATE_W + ID_W + SH_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_COUNT - 1);

  // Request registers
  logic [1:0]        op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ID_W-1:0]   src_r;

  // Directory store and its read register
  logic [ENTRY_W-1:0] dir_mem_r [LINE_COUNT];
  logic [ENTRY_W-1:0] rd_r;
  logic [IDX_W-1:0]   clr_ptr_r;
  logic [IDX_W-1:0]   line_idx;
  logic               idx_done;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  // Entry fields and update
  logic [LSTATE_W-1:0] ent_state;
  logic [ID_W-1:0]     ent_owner;
  logic [SH_W-1:0]     ent_sh;
  logic [SH_W-1:0]     src_bit;
  logic                req_ok;
  logic [LSTATE_W-1:0] new_state;
  logic [ID_W-1:0]     new_owner;
  logic [SH_W-1:0]     new_sh;
  logic [SH_W-1:0]     mask_load;
  logic [1:0]          fin_type_nxt;
  logic [1:0]          fin_kind_nxt;
  logic [ID_W-1:0]     fin_cache_nxt;

  // Message sequencing
  logic [SH_W-1:0]     mask_r;
  logic [SH_W-1:0]     mask_rest;
  logic [ID_W-1:0]     inv_dest;
  logic [1:0]          fin_type_r;
  logic [1:0]          fin_kind_r;
  logic [ID_W-1:0]     fin_cache_r;

  // Output register
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [1:0]          out_msg_type_r;
  logic [ID_W-1:0]     out_dest_id_r;
  logic [1:0]          out_sender_kind_r;
  logic [ID_W-1:0]     out_sender_cache_r;
  logic [ADDR_W-1:0]   out_msg_address_r;
  logic                out_last_r;

  cdir_line_index #(
    .LINE_COUNT (LINE_COUNT)
  ) u_line_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.accept),
    .address (in_address),
    .done    (idx_done),
    .index   (line_idx)
  );

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_operation;
      addr_r <= in_address;
      src_r  <= in_source_id;
    end
  end

  // Sweep the store to uncached after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
    end else if (cmd.clear) begin
      clr_ptr_r <= clr_ptr_r + IDX_W'(1);
    end
  end

  assign mem_we = cmd.clear || (cmd.eval && req_ok);
  assign mem_wa = cmd.clear ? clr_ptr_r : line_idx;
  assign mem_wd = cmd.clear ? '0 : {new_state, new_owner, new_sh};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dir_mem_r[mem_wa] <= mem_wd;
    end
    if (cmd.mem_read) begin
      rd_r <= dir_mem_r[line_idx];
    end
  end

  assign ent_state = rd_r[ENTRY_W-1 -: LSTATE_W];
  assign ent_owner = rd_r[SH_W +: ID_W];
  assign ent_sh    = rd_r[SH_W-1:0];
  assign src_bit   = SH_W'(1) << src_r;
  assign req_ok    = (op_r inside {OP_READ, OP_WRITE, OP_INV_ACK})
                     && (int'(src_r) < CACHE_COUNT);

  // Apply the request to the line entry
  always_comb begin
    new_state     = ent_state;
    new_owner     = ent_owner;
    new_sh        = ent_sh;
    mask_load     = '0;
    fin_type_nxt  = MT_READ_ACK;
    fin_kind_nxt  = SK_MEMORY;
    fin_cache_nxt = '0;
    case (op_r)
      OP_READ: begin
        new_sh = ent_sh | src_bit;
        if (ent_state == LS_UNCACHED) begin
          new_state = LS_SHARED;
          new_owner = src_r;
        end else begin
          fin_kind_nxt  = SK_CACHE;
          fin_cache_nxt = ent_owner;
        end
      end
      OP_WRITE: begin
        if (ent_state != LS_UNCACHED) begin
          mask_load = ent_sh & ~src_bit;
        end
        new_state    = LS_EXCLUSIVE;
        new_owner    = src_r;
        new_sh       = src_bit;
        fin_type_nxt = MT_WRITE_ACK;
        fin_kind_nxt = SK_DIRECTORY;
      end
      OP_INV_ACK: begin
        new_sh = ent_sh & ~src_bit;
        if (new_sh == '0) begin
          new_state = LS_UNCACHED;
          new_owner = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Lowest pending invalidate target
  always_comb begin
    inv_dest = '0;
    for (int c = SH_W - 1; c >= 0; c--) begin
      if (mask_r[c]) begin
        inv_dest = ID_W'(c);
      end
    end
  end

  assign mask_rest = mask_r & (mask_r - SH_W'(1));

  // Hold the pending invalidates and the closing message
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      mask_r      <= req_ok ? mask_load : '0;
      fin_type_r  <= fin_type_nxt;
      fin_kind_r  <= fin_kind_nxt;
      fin_cache_r <= fin_cache_nxt;
    end else if (cmd.send && mask_r != '0) begin
      mask_r <= mask_rest;
    end
  end

  // Load the output register: invalidates first, then the closing message
  always_ff @(posedge clk) begin
    if (cmd.send) begin
      out_msg_address_r <= addr_r;
      if (mask_r != '0) begin
        out_msg_type_r     <= MT_INVALIDATE;
        out_dest_id_r      <= inv_dest;
        out_sender_kind_r  <= SK_DIRECTORY;
        out_sender_cache_r <= '0;
        out_last_r         <= 1'b0;
      end else begin
        out_msg_type_r     <= fin_type_r;
        out_dest_id_r      <= src_r;
        out_sender_kind_r  <= fin_kind_r;
        out_sender_cache_r <= fin_cache_r;
        out_last_r         <= 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.send) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.clear_last = (clr_ptr_r == LAST_IDX);
  assign status.idx_done   = idx_done;
  assign status.has_final  = req_ok && (op_r != OP_INV_ACK);
  assign status.out_free   = !out_valid_r || out_ready;
  assign status.mask_empty = (mask_r == '0);

  assign out_valid        = out_valid_r;
  assign out_msg_type     = out_msg_type_r;
  assign out_dest_id      = out_dest_id_r;
  assign out_sender_kind  = out_sender_kind_r;
  assign out_sender_cache = out_sender_cache_r;
  assign out_msg_address  = out_msg_address_r;
  assign out_last         = out_last_r;

endmodule

[design/cdir_ctrl.sv]
module cdir_ctrl import cdir_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  cdir_status_t status,
  output cdir_cmd_t    cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (status.idx_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = status.has_final ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        if (status.out_free && status.mask_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_INDEX: begin
        cmd.mem_read = status.idx_done;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_SEND: begin
        cmd.send = status.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/coherence_directory_controller.sv]
// Central MSI coherence directory.
// in_req carries one request per beat (operation, address, source_id);
// out_msg carries the messages it causes, the final one flagged by last.
// A read gives one read acknowledge, from memory or from the recorded
// owner. A write gives one invalidate per other sharer, lowest cache first,
// then a write acknowledge. An invalidate acknowledge gives no message.
// A request passes from accept through the index, evaluate and send states to
// its first message in the output register; when LINE_COUNT is not a power
// of two the line index comes from a reciprocal multiplication through the
// high word, quotient and remainder registers. Each further invalidate is
// loaded in turn from the send state. One request is in work at a time, and
// in_req.ready rises again once the last message is loaded, even while it
// waits on out_msg. Reset: a clearing pass writes every line to uncached;
// in_req.ready stays low until it ends.
// When the receiver stalls, the output register holds its beat and further
// invalidates wait behind it.
module coherence_directory_controller import cdir_pkg::*; #(
  parameter int CACHE_COUNT = CDIR_CACHE_COUNT,
  parameter int LINE_COUNT  = CDIR_LINE_COUNT
) (
  input logic        clk,
  input logic        rst_n,
  cdir_req_if.sink   in_req,
  cdir_msg_if.source out_msg
);

  cdir_cmd_t    cmd;
  cdir_status_t status;

  cdir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cdir_dpath #(
    .CACHE_COUNT (CACHE_COUNT),
    .LINE_COUNT  (LINE_COUNT)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_operation     (in_req.operation),
    .in_address       (in_req.address),
    .in_source_id     (in_req.source_id),
    .out_valid        (out_msg.valid),
    .out_ready        (out_msg.ready),
    .out_msg_type     (out_msg.msg_type),
    .out_dest_id      (out_msg.dest_id),
    .out_sender_kind  (out_msg.sender_kind),
    .out_sender_cache (out_msg.sender_cache),
    .out_msg_address  (out_msg.msg_address),
    .out_last         (out_msg.last)
  );

`ifndef ASSERT_OFF
  // One request in work at a time
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request accepted while another is in work");

  // Never overwrite a beat the receiver has not taken
  a_send_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send |-> status.out_free)
    else $error("output register loaded while occupied");

  // Invalidates are never the closing message
  a_inv_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_msg.valid && out_msg.msg_type == MT_INVALIDATE |-> !out_msg.last)
    else $error("invalidate flagged as last");

  // Acknowledges always close a request
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_msg.valid && (out_msg.msg_type == MT_READ_ACK || out_msg.msg_type == MT_WRITE_ACK)
    |-> out_msg.last)
    else $error("acknowledge not flagged as last");
`endif

endmodule
